>>> sv/fuc_pkg.sv
`default_nettype none

package fuc_pkg;

    localparam int CHAR_BITS   = 8;
    localparam int CHAR_COUNT  = 1 << CHAR_BITS;
    localparam int BYTE_BITS   = 8;
    localparam int STATUS_BITS = 2;

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef logic [BYTE_BITS-1:0] byte_t;

    // A stored value of three never arises and is handled like repeated.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_UNSEEN   = 2'd0,
        ST_ONCE     = 2'd1,
        ST_REPEATED = 2'd2
    } status_t;

    typedef struct packed {
        logic    en;
        char_t   addr;
        status_t data;
    } status_wr_t;

    typedef struct packed {
        logic  en;
        char_t addr;
        char_t data;
    } link_wr_t;

    typedef struct packed {
        byte_t first_unique;
        logic  found;
    } result_t;

endpackage

`default_nettype wire

>>> sv/fuc_in_if.sv
`default_nettype none

interface fuc_in_if import fuc_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t ch;
    logic  starts_string;

    modport source (output valid, output ch, output starts_string, input ready);
    modport sink   (input valid, input ch, input starts_string, output ready);
endinterface

`default_nettype wire

>>> sv/fuc_out_if.sv
`default_nettype none

interface fuc_out_if import fuc_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t first_unique;
    logic  found;

    modport source (output valid, output first_unique, output found, input ready);
    modport sink   (input valid, input first_unique, input found, output ready);
endinterface

`default_nettype wire

>>> sv/fuc_ram.sv
`default_nettype none

module fuc_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/fuc_list_ctrl.sv
`default_nettype none

module fuc_list_ctrl import fuc_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire byte_t                  ch,
    input  wire logic                   starts_string,
    input  wire logic [STATUS_BITS-1:0] status_rd,
    input  wire char_t                  next_rd,
    input  wire char_t                  prev_rd,
    output status_wr_t                  status_wr,
    output link_wr_t                    next_wr,
    output link_wr_t                    prev_wr,
    output logic                        push,
    output result_t                     result
);

    logic                  s1_valid_reg;
    char_t                 s1_ch_reg;
    logic                  s1_start_reg;

    logic [CHAR_COUNT-1:0] seen_reg;
    logic [CHAR_COUNT-1:0] seen_next;
    char_t                 head_reg;
    char_t                 head_next;
    char_t                 tail_reg;
    char_t                 tail_next;
    logic                  nonempty_reg;
    logic                  nonempty_next;

    logic                  start;
    char_t                 c;
    char_t                 head_cur;
    char_t                 tail_cur;
    logic                  nonempty_cur;
    status_t               st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg    <= char_t'(ch);
            s1_start_reg <= starts_string;
        end
    end

    assign start        = s1_valid_reg && s1_start_reg;
    assign c            = s1_ch_reg;
    assign head_cur     = start ? '0 : head_reg;
    assign tail_cur     = start ? '0 : tail_reg;
    assign nonempty_cur = start ? 1'b0 : nonempty_reg;

    // The seen bits stand in for clearing the status memory: an entry not
    // marked since the last string start reads as unseen.
    assign st = (start || !seen_reg[c]) ? ST_UNSEEN : status_t'(status_rd);

    always_comb
    begin
        head_next      = head_cur;
        tail_next      = tail_cur;
        nonempty_next  = nonempty_cur;
        seen_next      = start ? '0 : seen_reg;
        status_wr.en   = 1'b0;
        status_wr.addr = c;
        status_wr.data = ST_ONCE;
        next_wr.en     = 1'b0;
        next_wr.addr   = tail_cur;
        next_wr.data   = c;
        prev_wr.en     = 1'b0;
        prev_wr.addr   = c;
        prev_wr.data   = tail_cur;

        if (s1_valid_reg)
        begin
            case (st)
                ST_UNSEEN:
                begin
                    seen_next[c]   = 1'b1;
                    status_wr.en   = 1'b1;
                    status_wr.data = ST_ONCE;
                    tail_next      = c;
                    if (nonempty_cur)
                    begin
                        next_wr.en = 1'b1;
                        prev_wr.en = 1'b1;
                    end
                    else
                    begin
                        head_next     = c;
                        nonempty_next = 1'b1;
                    end
                end
                ST_ONCE:
                begin
                    status_wr.en   = 1'b1;
                    status_wr.data = ST_REPEATED;
                    if ((head_cur == c) && (tail_cur == c))
                    begin
                        head_next     = '0;
                        tail_next     = '0;
                        nonempty_next = 1'b0;
                    end
                    else if (head_cur == c)
                    begin
                        head_next = next_rd;
                    end
                    else if (tail_cur == c)
                    begin
                        tail_next = prev_rd;
                    end
                    else
                    begin
                        // Bridge the neighbors around the character.
                        next_wr.en   = 1'b1;
                        next_wr.addr = prev_rd;
                        next_wr.data = next_rd;
                        prev_wr.en   = 1'b1;
                        prev_wr.addr = next_rd;
                        prev_wr.data = prev_rd;
                    end
                end
                default:
                begin
                    status_wr.en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
        end
    end

    assign push                = s1_valid_reg;
    assign result.first_unique = nonempty_next ? byte_t'(head_next) : '0;
    assign result.found        = nonempty_next;

endmodule

`default_nettype wire

>>> sv/fuc_out_buf.sv
`default_nettype none

module fuc_out_buf import fuc_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output logic         out_valid,
    output result_t      out_data,
    output logic [1:0]   count
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ pop;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

>>> sv/first_unique_char_stream.sv
// First non-repeating character of a character stream.
//
// chars (sink): one character per transaction, with starts_string set on the
// first character of a new string; that flag clears all state before the
// character is taken. Without it, characters continue the current string.
// results (source): one transaction per character, carrying the earliest
// character seen exactly once so far and a found flag (character 0 and found
// low when there is none).
//
// A result is registered in the list controller's stage and then in the
// output buffer before it becomes valid on the results interface.
// Throughput is one character per cycle while chars.ready is high: the
// character's status and list links are read from three memories in the
// cycle it is accepted and written back in the next, with write-to-read
// bypass in each memory covering back-to-back characters.
//
// Reset clears the list and the per-character seen flags at once, so the
// block takes characters as soon as reset is released. Results queue in a
// two-entry buffer; while the receiver stalls, chars.ready drops only when a
// further character would overflow that buffer.

`default_nettype none

module first_unique_char_stream import fuc_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    fuc_in_if.sink    chars,
    fuc_out_if.source results
);

    logic                   accept;
    logic                   pop;
    logic                   push;
    char_t                  rd_addr;
    logic [STATUS_BITS-1:0] status_rd;
    char_t                  next_rd;
    char_t                  prev_rd;
    status_wr_t             status_wr;
    link_wr_t               next_wr;
    link_wr_t               prev_wr;
    result_t                result;
    result_t                out_data;
    logic                   out_valid;
    logic [1:0]             count;
    logic [2:0]             load;

    assign accept  = chars.valid && chars.ready;
    assign pop     = results.valid && results.ready;
    assign rd_addr = char_t'(chars.ch);

    // Results held or in flight after this cycle must fit the buffer.
    assign load        = 3'(count) + 3'(push) - 3'(pop);
    assign chars.ready = (load <= 3'd1);

    fuc_ram #(
        .WIDTH     (STATUS_BITS),
        .ADDR_BITS (CHAR_BITS)
    ) u_status_ram (
        .clk     (clk),
        .wr_en   (status_wr.en),
        .wr_addr (status_wr.addr),
        .wr_data (status_wr.data),
        .rd_addr (rd_addr),
        .rd_data (status_rd)
    );

    fuc_ram #(
        .WIDTH     (CHAR_BITS),
        .ADDR_BITS (CHAR_BITS)
    ) u_next_ram (
        .clk     (clk),
        .wr_en   (next_wr.en),
        .wr_addr (next_wr.addr),
        .wr_data (next_wr.data),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    fuc_ram #(
        .WIDTH     (CHAR_BITS),
        .ADDR_BITS (CHAR_BITS)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_wr.en),
        .wr_addr (prev_wr.addr),
        .wr_data (prev_wr.data),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    fuc_list_ctrl u_list_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .ch            (chars.ch),
        .starts_string (chars.starts_string),
        .status_rd     (status_rd),
        .next_rd       (next_rd),
        .prev_rd       (prev_rd),
        .status_wr     (status_wr),
        .next_wr       (next_wr),
        .prev_wr       (prev_wr),
        .push          (push),
        .result        (result)
    );

    fuc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data),
        .count     (count)
    );

    assign results.valid        = out_valid;
    assign results.first_unique = out_data.first_unique;
    assign results.found        = out_data.found;

endmodule

`default_nettype wire

>>> sv/fuc_checker.sv
`default_nettype none

module fuc_checker import fuc_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_valid,
    input wire logic  in_ready,
    input wire byte_t in_ch,
    input wire logic  in_start,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire byte_t out_first_unique,
    input wire logic  out_found
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first_unique)
            && $stable(out_found))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_first_unique == '0)
    else $error("character reported without found");

    // Backpressure only comes from results waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

    // On an idle block, the first character of a string is its own answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_start && !out_valid && !$past(in_fire) |->
            ##2 (out_valid && out_found
                && out_first_unique == byte_t'(char_t'($past(in_ch, 2)))))
    else $error("wrong result for a string start");

endmodule

bind first_unique_char_stream fuc_checker u_fuc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (chars.valid),
    .in_ready         (chars.ready),
    .in_ch            (chars.ch),
    .in_start         (chars.starts_string),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .out_first_unique (results.first_unique),
    .out_found        (results.found)
);

`default_nettype wire
